>>> design/lfpd_pkg.sv
// Types, register codes, reset values and helpers shared by the line-follower steering block.
package lfpd_pkg;

  localparam int unsigned LevelW   = 12;
  localparam int unsigned DriveW   = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned NudgeW   = 15;
  localparam int unsigned ErrW     = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumLines = 8;
  localparam int unsigned WideW    = 24;

  localparam logic signed [DriveW-1:0] DriveFull   = 16'sd16384;
  localparam logic signed [DriveW-1:0] CruiseReset = -16'sd6554;

  localparam logic [LevelW-1:0] LineThrReset     = 12'd3481;
  localparam logic [LevelW-1:0] ObstacleThrReset = 12'd1024;
  localparam logic [GainW-1:0]  GainPReset       = 16'd4915;
  localparam logic [GainW-1:0]  GainDReset       = 16'd4915;
  localparam logic [NudgeW-1:0] NudgeReset       = 15'd819;

  localparam logic signed [ErrW-1:0] LineWeight [NumLines] = '{
    -5'sd4, -5'sd2, -5'sd1, 5'sd0, 5'sd0, 5'sd1, 5'sd2, 5'sd4
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineThr     = 3'd0,
    CfgObstacleThr = 3'd1,
    CfgGainP       = 3'd2,
    CfgGainD       = 3'd3,
    CfgCruise      = 3'd4,
    CfgNudge       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] front_level;
    logic [LevelW-1:0] line_0;
    logic [LevelW-1:0] line_1;
    logic [LevelW-1:0] line_2;
    logic [LevelW-1:0] line_3;
    logic [LevelW-1:0] line_4;
    logic [LevelW-1:0] line_5;
    logic [LevelW-1:0] line_6;
    logic [LevelW-1:0] line_7;
    logic [LevelW-1:0] right_level;
    logic [LevelW-1:0] left_level;
  } sample_t;

  typedef struct packed {
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
  } drive_t;

  typedef struct packed {
    logic [LevelW-1:0]        line_threshold;
    logic [LevelW-1:0]        obstacle_threshold;
    logic [GainW-1:0]         gain_p;
    logic [GainW-1:0]         gain_d;
    logic signed [DriveW-1:0] cruise_speed;
    logic [NudgeW-1:0]        nudge_step;
  } cfg_t;

  typedef struct packed {
    logic signed [DriveW-1:0] left_speed;
    logic signed [DriveW-1:0] right_speed;
    logic signed [ErrW-1:0]   prev_error;
  } steer_state_t;

  // Clamps a wide signed drive value to the range of full reverse to full forward.
  function automatic logic signed [DriveW-1:0] sat_drive(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] full_w;
    full_w = WideW'(DriveFull);
    if (v > full_w) begin
      return DriveFull;
    end else if (v < -full_w) begin
      return -DriveFull;
    end else begin
      return v[DriveW-1:0];
    end
  endfunction

endpackage

>>> design/lfpd_in_if.sv
// Sensor sample channel of the line-follower steering block.
interface lfpd_in_if
  import lfpd_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/lfpd_out_if.sv
// Drive result channel of the line-follower steering block.
interface lfpd_out_if
  import lfpd_pkg::*;
();
  logic   valid;
  logic   ready;
  drive_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/lfpd_update.sv
// Combinational steering update: obstacle stop, line-lost nudge, cruise restore and PD correction.
module lfpd_update
  import lfpd_pkg::*;
(
  input  sample_t      sample_i,
  input  cfg_t         cfg_i,
  input  steer_state_t state_i,
  output steer_state_t state_o
);

  logic [LevelW-1:0]        lines [NumLines];
  logic [NumLines-1:0]      seen;
  logic signed [ErrW-1:0]   err_sum;
  logic signed [ErrW-1:0]   err;
  logic signed [ErrW:0]     diff;
  logic signed [ErrW:0]     diff_adj;
  logic signed [ErrW-1:0]   half_diff;
  logic signed [21:0]       prod_p;
  logic signed [21:0]       prod_d;
  logic signed [22:0]       pd;
  logic signed [WideW-1:0]  left_w;
  logic signed [WideW-1:0]  right_w;
  logic signed [WideW-1:0]  nudge_w;
  logic signed [WideW-1:0]  pd_w;
  logic signed [DriveW-1:0] cruise_sat;

  always_comb begin
    lines[0] = sample_i.line_0;
    lines[1] = sample_i.line_1;
    lines[2] = sample_i.line_2;
    lines[3] = sample_i.line_3;
    lines[4] = sample_i.line_4;
    lines[5] = sample_i.line_5;
    lines[6] = sample_i.line_6;
    lines[7] = sample_i.line_7;

    err_sum = '0;
    for (int i = 0; i < NumLines; i++) begin
      seen[i] = lines[i] > cfg_i.line_threshold;
      if (seen[i]) begin
        err_sum = err_sum + LineWeight[i];
      end
    end

    // An error sum of four either way, as from a lone edge reading, is pushed further out to steer harder.
    if (err_sum == 5'sd4) begin
      err = 5'sd8;
    end else if (err_sum == -5'sd4) begin
      err = -5'sd8;
    end else begin
      err = err_sum;
    end

    // Halve the error change, rounding toward zero.
    diff      = {err[ErrW-1], err} - {state_i.prev_error[ErrW-1], state_i.prev_error};
    diff_adj  = diff + {{ErrW{1'b0}}, diff[ErrW]};
    half_diff = ErrW'(diff_adj >>> 1);

    prod_p = err * $signed({1'b0, cfg_i.gain_p});
    prod_d = half_diff * $signed({1'b0, cfg_i.gain_d});
    pd     = {prod_p[21], prod_p} + {prod_d[21], prod_d};

    left_w     = WideW'(state_i.left_speed);
    right_w    = WideW'(state_i.right_speed);
    nudge_w    = $signed({{(WideW-NudgeW){1'b0}}, cfg_i.nudge_step});
    pd_w       = WideW'(pd);
    cruise_sat = sat_drive(WideW'(cfg_i.cruise_speed));

    state_o = state_i;
    if (sample_i.front_level < cfg_i.obstacle_threshold) begin
      state_o.left_speed  = '0;
      state_o.right_speed = '0;
    end else if (seen == '0) begin
      if (sample_i.right_level > sample_i.left_level) begin
        state_o.left_speed  = sat_drive(left_w + nudge_w);
        state_o.right_speed = sat_drive(right_w - nudge_w);
      end else if (sample_i.left_level > sample_i.right_level) begin
        state_o.left_speed  = sat_drive(left_w - nudge_w);
        state_o.right_speed = sat_drive(right_w + nudge_w);
      end
    end else if (err == '0) begin
      state_o.left_speed  = cruise_sat;
      state_o.right_speed = cruise_sat;
    end else begin
      state_o.left_speed  = sat_drive(left_w + pd_w);
      state_o.right_speed = sat_drive(right_w - pd_w);
      state_o.prev_error  = err;
    end
  end

endmodule

>>> design/line_follow_pd_steering.sv
// Top level of the line-follower steering block with PD correction.
//
//   Channel   Direction  Carries
//   sample_i  in         front, eight line and two side sensor levels
//   drive_o   out        new left and right drive, Q1.14
//   cfg_*     in         register writes: thresholds, gains, cruise speed, nudge step
//
// A transaction is held in the input register and then leaves through the result
// register, so one transaction is taken every cycle while the result side does not stall.
// The drive state is updated as a transaction moves into the result register, which
// holds the current drives. When the result side stalls, the input register holds one
// more transaction before the input side sees ready low. Reset clears the valid flags
// and loads the register and drive reset values.
module line_follow_pd_steering
  import lfpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  lfpd_in_if.sink             sample_i,
  lfpd_out_if.source          drive_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t         cfg_q;
  logic         in_valid_q;
  sample_t      in_data_q;
  logic         out_valid_q;
  steer_state_t state_q;
  steer_state_t state_d;
  logic         accept;
  logic         advance;

  assign advance         = in_valid_q && (!out_valid_q || drive_o.ready);
  assign sample_i.ready  = !in_valid_q || advance;
  assign accept          = sample_i.valid && sample_i.ready;
  assign drive_o.valid   = out_valid_q;
  assign drive_o.data    = '{left_drive: state_q.left_speed, right_drive: state_q.right_speed};

  lfpd_update u_update (
    .sample_i (in_data_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_threshold     <= LineThrReset;
      cfg_q.obstacle_threshold <= ObstacleThrReset;
      cfg_q.gain_p             <= GainPReset;
      cfg_q.gain_d             <= GainDReset;
      cfg_q.cruise_speed       <= CruiseReset;
      cfg_q.nudge_step         <= NudgeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLineThr:     cfg_q.line_threshold     <= cfg_wdata_i[LevelW-1:0];
        CfgObstacleThr: cfg_q.obstacle_threshold <= cfg_wdata_i[LevelW-1:0];
        CfgGainP:       cfg_q.gain_p             <= cfg_wdata_i[GainW-1:0];
        CfgGainD:       cfg_q.gain_d             <= cfg_wdata_i[GainW-1:0];
        CfgCruise:      cfg_q.cruise_speed       <= $signed(cfg_wdata_i[DriveW-1:0]);
        CfgNudge:       cfg_q.nudge_step         <= cfg_wdata_i[NudgeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.left_speed  <= CruiseReset;
      state_q.right_speed <= CruiseReset;
      state_q.prev_error  <= '0;
    end else begin
      in_valid_q  <= accept || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !drive_o.ready);
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= sample_i.data;
    end
  end

endmodule
